@@ rtl/gsp_pkg.sv @@
package gsp_pkg;

    typedef enum logic [2:0] {
        FUNC_START  = 3'd0,
        FUNC_UPDATE = 3'd1,
        FUNC_STOP   = 3'd2,
        FUNC_TICK   = 3'd3,
        FUNC_RESET  = 3'd4
    } func_t;

    // classified operation carried from front to back
    typedef enum logic [2:0] {
        OP_START,
        OP_UPDATE,
        OP_STOP,
        OP_TICK,
        OP_RESET,
        OP_BAD
    } op_t;

    typedef enum logic [1:0] {
        MODE_FREE   = 2'd0,
        MODE_ACTIVE = 2'd1,
        MODE_DRAIN  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_NOSLOT  = 3'd2,
        ST_DUP     = 3'd3,
        ST_BADSTOP = 3'd4,
        ST_UNKNOWN = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CFG_ACTIVE_LIMIT = 2'd0,
        CFG_DRAIN_TIME   = 2'd1,
        CFG_READY        = 2'd2
    } cfg_idx_t;

    localparam int CNT_ACQUIRE  = 0;
    localparam int CNT_SHORT    = 1;
    localparam int CNT_STOP     = 2;
    localparam int CNT_DRAIN    = 3;
    localparam int CNT_RELEASE  = 4;
    localparam int CNT_DUPSTART = 5;
    localparam int CNT_DUPSTOP  = 6;
    localparam int CNT_BADXF    = 7;
    localparam int NUM_CNT      = 8;

    localparam int DT_W = 13;
    localparam logic [31:0]     MIN_DRAIN = 32'd655;
    localparam logic [15:0]     MAX_STEP  = 16'd4369;
    localparam logic [4:0]      LIMIT_RST = 5'd16;
    localparam logic [31:0]     DRAIN_RST = 32'd65536;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] handle;
        logic        transform_ok;
        logic [15:0] delta_time;
        logic        clear_stats;
        logic [2:0]  stat_select;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] handle_out;
        logic [2:0]  status;
        logic [1:0]  last_state;
        logic [4:0]  released;
        logic [31:0] stat_value;
    } rsp_t;

    typedef struct packed {
        logic [4:0]  active_limit;
        logic [31:0] drain_time;
        logic        ready_cfg;
    } cfg_t;

    typedef struct packed {
        op_t             op;
        logic [63:0]     handle;
        logic            hdl_in;
        logic            xf_ok;
        logic [DT_W-1:0] dt;
        logic            clr;
        logic [2:0]      sel;
    } item_t;

endpackage

@@ rtl/gsp_front.sv @@
module gsp_front
    import gsp_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic  start,
    input  logic  full,
    input  req_t  req,
    output logic  push,
    output item_t item
);

    logic [31:0] lo;
    logic [31:0] gen;

    assign lo   = req.handle[31:0];
    assign gen  = req.handle[63:32];
    assign push = start && !full;

    always_comb
    begin
        case (req.func)
            FUNC_START:  item.op = OP_START;
            FUNC_UPDATE: item.op = OP_UPDATE;
            FUNC_STOP:   item.op = OP_STOP;
            FUNC_TICK:   item.op = OP_TICK;
            FUNC_RESET:  item.op = OP_RESET;
            default:     item.op = OP_BAD;
        endcase
        item.handle = req.handle;
        // slot field in range and generation nonzero
        item.hdl_in = (lo != 32'd0) && (lo <= 32'(SLOTS)) && (gen != 32'd0);
        item.xf_ok  = req.transform_ok;
        item.dt     = (req.delta_time > MAX_STEP) ? MAX_STEP[DT_W-1:0]
                                                  : req.delta_time[DT_W-1:0];
        item.clr    = req.clear_stats;
        item.sel    = req.stat_select;
    end

endmodule

@@ rtl/gsp_queue.sv @@
module gsp_queue
    import gsp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_data,
    input  logic  pop,
    output logic  full,
    output logic  nonempty,
    output item_t head
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign nonempty = (count_reg != 2'd0);
    assign head     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/gsp_back.sv @@
module gsp_back
    import gsp_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_valid,
    input  item_t q_data,
    output logic  pop,
    input  cfg_t  cfg,
    output logic  done,
    output rsp_t  rsp
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

    typedef enum logic [1:0] {
        B_IDLE,
        B_EVAL,
        B_SWEEP
    } bstate_t;

    // slot memories; an entry without its valid bit reads as free, gen 1, drain 0
    mode_t       mode_mem  [SLOTS];
    logic [31:0] gen_mem   [SLOTS];
    logic [31:0] drain_mem [SLOTS];

    mode_t       mode_rd_reg;
    logic [31:0] gen_rd_reg;
    logic [31:0] drain_rd_reg;
    logic        vld_rd_reg;

    bstate_t        state_reg,  state_next;
    item_t          cur_reg,    cur_next;
    logic [SW-1:0]  chk_reg,    chk_next;
    logic [4:0]     rel_reg,    rel_next;
    logic [63:0]    last_h_reg, last_h_next;
    mode_t          last_m_reg, last_m_next;
    logic [31:0]    ev_reg [NUM_CNT];
    logic [31:0]    ev_next [NUM_CNT];
    logic [SLOTS-1:0] vld_reg;
    logic           done_reg;
    rsp_t           rsp_reg,    rsp_next;

    logic [SW-1:0]  rd_addr;
    logic           wr_en;
    logic [SW-1:0]  wr_addr;
    mode_t          wr_mode;
    logic [31:0]    wr_gen;
    logic [31:0]    wr_drain;

    logic [SW-1:0]  hd_idx;
    logic [SW-1:0]  cur_idx;
    logic [SW-1:0]  lim_m1;
    mode_t          m_eff;
    logic [31:0]    g_eff;
    logic [31:0]    d_eff;
    logic [31:0]    g_inc;
    logic [31:0]    g_bump;
    logic [31:0]    d_left;
    logic [31:0]    drain_use;
    logic [63:0]    chk_h;
    logic           dec;
    logic [4:0]     rel_inc;

    logic [NUM_CNT-1:0] inc;
    logic           clr_ev;
    logic           emit;
    logic           r_ok;
    logic [63:0]    r_hout;
    status_t        r_status;
    logic [4:0]     r_rel;
    logic [2:0]     sel;

    assign done = done_reg;
    assign rsp  = rsp_reg;

    assign hd_idx  = q_data.handle[SW-1:0] - 1'b1;
    assign cur_idx = cur_reg.handle[SW-1:0] - 1'b1;

    assign m_eff  = vld_rd_reg ? mode_rd_reg : MODE_FREE;
    assign g_eff  = vld_rd_reg ? gen_rd_reg : 32'd1;
    assign d_eff  = vld_rd_reg ? drain_rd_reg : 32'd0;
    assign g_inc  = g_eff + 32'd1;
    assign g_bump = (g_inc == 32'd0) ? 32'd1 : g_inc;
    assign d_left = (d_eff > {{(32-DT_W){1'b0}}, cur_reg.dt})
                  ? d_eff - {{(32-DT_W){1'b0}}, cur_reg.dt} : 32'd0;
    assign drain_use = (cfg.drain_time < MIN_DRAIN) ? MIN_DRAIN : cfg.drain_time;
    assign chk_h  = {g_eff, {{(32-SW){1'b0}}, chk_reg} + 32'd1};
    assign dec    = cur_reg.hdl_in && (cur_reg.handle[63:32] == g_eff)
                 && (m_eff != MODE_FREE);
    assign rel_inc = rel_reg + 5'd1;

    always_comb
    begin
        if (cfg.active_limit == 5'd0)
        begin
            lim_m1 = '0;
        end
        else if (int'(cfg.active_limit) > SLOTS)
        begin
            lim_m1 = LAST;
        end
        else
        begin
            lim_m1 = SW'(cfg.active_limit - 5'd1);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        chk_next    = chk_reg;
        rel_next    = rel_reg;
        last_h_next = last_h_reg;
        last_m_next = last_m_reg;
        pop         = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = cur_idx;
        wr_mode     = MODE_FREE;
        wr_gen      = g_eff;
        wr_drain    = 32'd0;
        inc         = '0;
        clr_ev      = 1'b0;
        emit        = 1'b0;
        r_ok        = 1'b0;
        r_hout      = 64'd0;
        r_status    = ST_INVALID;
        r_rel       = 5'd0;
        sel         = cur_reg.sel;

        case (state_reg)
            B_IDLE:
            begin
                sel = q_data.sel;
                if ((q_data.op == OP_START || q_data.op == OP_UPDATE ||
                     q_data.op == OP_STOP) && q_data.hdl_in)
                begin
                    rd_addr = hd_idx;
                end
                if (q_valid)
                begin
                    pop      = 1'b1;
                    cur_next = q_data;
                    chk_next = '0;
                    rel_next = 5'd0;
                    case (q_data.op)
                        OP_START, OP_UPDATE, OP_STOP:
                        begin
                            state_next = B_EVAL;
                        end
                        OP_TICK:
                        begin
                            if (cfg.ready_cfg)
                            begin
                                state_next = B_SWEEP;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        OP_RESET:
                        begin
                            state_next = B_SWEEP;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end

            B_EVAL:
            begin
                emit = 1'b1;
                case (cur_reg.op)
                    OP_START:
                    begin
                        if (dec)
                        begin
                            inc[CNT_DUPSTART] = 1'b1;
                            r_status = ST_DUP;
                            if (m_eff == MODE_ACTIVE)
                            begin
                                r_ok   = 1'b1;
                                r_hout = cur_reg.handle;
                            end
                        end
                        else if (!cfg.ready_cfg || !cur_reg.xf_ok)
                        begin
                            inc[CNT_BADXF] = 1'b1;
                        end
                        else
                        begin
                            // scan from slot 0; its read goes out now
                            emit       = 1'b0;
                            chk_next   = '0;
                            state_next = B_SWEEP;
                        end
                    end
                    OP_UPDATE, OP_STOP:
                    begin
                        if (!dec || m_eff != MODE_ACTIVE)
                        begin
                            if (cur_reg.op == OP_UPDATE)
                            begin
                                r_status = ST_UNKNOWN;
                            end
                            else
                            begin
                                r_status = ST_BADSTOP;
                                inc[CNT_DUPSTOP] = (cur_reg.handle != 64'd0);
                            end
                        end
                        else if (cur_reg.op == OP_UPDATE && cur_reg.xf_ok)
                        begin
                            last_h_next = cur_reg.handle;
                            last_m_next = MODE_ACTIVE;
                            r_ok        = 1'b1;
                            r_status    = ST_OK;
                        end
                        else
                        begin
                            // begin draining the slot
                            wr_en          = 1'b1;
                            wr_mode        = MODE_DRAIN;
                            wr_drain       = drain_use;
                            inc[CNT_STOP]  = 1'b1;
                            inc[CNT_DRAIN] = 1'b1;
                            last_h_next    = cur_reg.handle;
                            last_m_next    = MODE_DRAIN;
                            if (cur_reg.op == OP_UPDATE)
                            begin
                                inc[CNT_BADXF] = 1'b1;
                            end
                            else
                            begin
                                r_ok     = 1'b1;
                                r_status = ST_OK;
                            end
                        end
                    end
                    default:
                    begin
                        r_status = ST_INVALID;
                    end
                endcase
                if (emit)
                begin
                    state_next = B_IDLE;
                end
            end

            B_SWEEP:
            begin
                rd_addr  = (chk_reg == LAST) ? '0 : chk_reg + 1'b1;
                chk_next = chk_reg + 1'b1;
                wr_addr  = chk_reg;
                case (cur_reg.op)
                    OP_START:
                    begin
                        if (m_eff == MODE_FREE)
                        begin
                            wr_en            = 1'b1;
                            wr_mode          = MODE_ACTIVE;
                            last_h_next      = chk_h;
                            last_m_next      = MODE_ACTIVE;
                            inc[CNT_ACQUIRE] = 1'b1;
                            r_hout           = chk_h;
                            r_ok             = 1'b1;
                            r_status         = ST_OK;
                            emit             = 1'b1;
                        end
                        else if (chk_reg == lim_m1)
                        begin
                            inc[CNT_SHORT] = 1'b1;
                            r_status       = ST_NOSLOT;
                            emit           = 1'b1;
                        end
                    end
                    OP_TICK:
                    begin
                        r_rel = rel_reg;
                        if (m_eff == MODE_DRAIN)
                        begin
                            wr_en = 1'b1;
                            if (d_left != 32'd0)
                            begin
                                wr_mode  = MODE_DRAIN;
                                wr_drain = d_left;
                            end
                            else
                            begin
                                wr_gen           = g_bump;
                                inc[CNT_RELEASE] = 1'b1;
                                rel_next         = rel_inc;
                                r_rel            = rel_inc;
                                if (last_h_reg == chk_h)
                                begin
                                    last_m_next = MODE_FREE;
                                end
                            end
                        end
                        if (chk_reg == LAST)
                        begin
                            r_ok     = 1'b1;
                            r_status = ST_OK;
                            emit     = 1'b1;
                        end
                    end
                    OP_RESET:
                    begin
                        wr_en  = 1'b1;
                        wr_gen = g_bump;
                        if (chk_reg == LAST)
                        begin
                            last_h_next = 64'd0;
                            last_m_next = MODE_FREE;
                            clr_ev      = cur_reg.clr;
                            r_ok        = 1'b1;
                            r_status    = ST_OK;
                            emit        = 1'b1;
                        end
                    end
                    default:
                    begin
                        emit = 1'b1;
                    end
                endcase
                if (emit)
                begin
                    state_next = B_IDLE;
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        for (int k = 0; k < NUM_CNT; k++)
        begin
            ev_next[k] = clr_ev ? 32'd0 : ev_reg[k] + {31'd0, inc[k]};
        end

        rsp_next.ok         = r_ok;
        rsp_next.handle_out = r_hout;
        rsp_next.status     = r_status;
        rsp_next.last_state = last_m_next;
        rsp_next.released   = r_rel;
        rsp_next.stat_value = ev_next[sel];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            chk_reg    <= '0;
            rel_reg    <= 5'd0;
            last_h_reg <= 64'd0;
            last_m_reg <= MODE_FREE;
            vld_reg    <= '0;
            done_reg   <= 1'b0;
            for (int k = 0; k < NUM_CNT; k++)
            begin
                ev_reg[k] <= 32'd0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            chk_reg    <= chk_next;
            rel_reg    <= rel_next;
            last_h_reg <= last_h_next;
            last_m_reg <= last_m_next;
            done_reg   <= emit;
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            for (int k = 0; k < NUM_CNT; k++)
            begin
                ev_reg[k] <= ev_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mode_mem[wr_addr]  <= wr_mode;
            gen_mem[wr_addr]   <= wr_gen;
            drain_mem[wr_addr] <= wr_drain;
        end
        mode_rd_reg  <= mode_mem[rd_addr];
        gen_rd_reg   <= gen_mem[rd_addr];
        drain_rd_reg <= drain_mem[rd_addr];
        vld_rd_reg   <= vld_reg[rd_addr];
    end

endmodule

@@ rtl/generational_slot_pool_with_drain.sv @@
// Slot pool handing out generational handles (generation in bits 63..32,
// slot plus one in bits 31..0). A request is taken when start is high and
// busy is low; busy rises only when two requests already wait in the input
// queue. Requests run one at a time in order, each giving exactly one
// response with a one-cycle done pulse that cannot be stalled. After leaving
// the queue, an unknown op or a tick while not ready is answered from idle;
// update, stop and a duplicate or refused start from the eval state after
// the slot read; a start scans for a free slot up to the active limit
// (clamped to 1..SLOTS), and tick and reset sweep every slot, all through
// the single read port of the slot memory, swept one slot per cycle.
// Slot state is valid straight out of reset; no clearing pass is needed.
// Configuration writes are taken at any time but belong to idle periods.
module generational_slot_pool_with_drain
    import gsp_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        req,
    output logic        done,
    output rsp_t        rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [31:0] cfg_data
);

    logic [4:0]  limit_reg;
    logic [31:0] drain_reg;
    logic        ready_reg;
    cfg_t        cfg;

    logic  push;
    logic  pop;
    logic  full;
    logic  nonempty;
    item_t push_item;
    item_t head_item;

    assign busy = full;
    assign cfg.active_limit = limit_reg;
    assign cfg.drain_time   = drain_reg;
    assign cfg.ready_cfg    = ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RST;
            drain_reg <= DRAIN_RST;
            ready_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_ACTIVE_LIMIT: limit_reg <= cfg_data[4:0];
                CFG_DRAIN_TIME:   drain_reg <= cfg_data;
                CFG_READY:        ready_reg <= cfg_data[0];
                default:          ready_reg <= ready_reg;
            endcase
        end
    end

    gsp_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .start (start),
        .full  (full),
        .req   (req),
        .push  (push),
        .item  (push_item)
    );

    gsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_item),
        .pop       (pop),
        .full      (full),
        .nonempty  (nonempty),
        .head      (head_item)
    );

    gsp_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (nonempty),
        .q_data  (head_item),
        .pop     (pop),
        .cfg     (cfg),
        .done    (done),
        .rsp     (rsp)
    );

endmodule

@@ rtl/gsp_checker.sv @@
module gsp_checker
    import gsp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic done,
    input rsp_t rsp
);

    // success is only plain ok or a duplicate start on an active slot
    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.ok |-> (rsp.status == ST_OK || rsp.status == ST_DUP))
        else $error("ok response with failing status");

    a_handle_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.handle_out != 64'd0) |-> rsp.ok)
        else $error("handle returned on failed request");

    a_release_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.released != 5'd0) |-> rsp.ok && (rsp.status == ST_OK))
        else $error("slots released by a failed request");

    // a fresh allocation leaves its slot as the last one touched, active
    a_alloc_active: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status == ST_OK) && (rsp.handle_out != 64'd0)
        |-> rsp.last_state == MODE_ACTIVE)
        else $error("allocation not reported active");

endmodule

bind generational_slot_pool_with_drain gsp_checker u_gsp_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .done  (done),
    .rsp   (rsp)
);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import gsp_pkg::*;

    localparam int SLOTS = 16;
    localparam int LIMIT = 400000;
    localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
    localparam logic [1:0] CFG_SPARE = 2'd3;

    class pool_scoreboard;
        mode_t       slot_mode[SLOTS];
        logic [31:0] slot_gen[SLOTS];
        logic [31:0] drain_left[SLOTS];
        logic [63:0] last_handle;
        mode_t       last_mode;
        logic [31:0] counts[NUM_CNT];
        logic [4:0]  limit;
        logic [31:0] drain_time;
        logic        ready;
        rsp_t        awaited_rsp[$];
        int          fails;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_mode[i] = MODE_FREE;
                slot_gen[i] = 32'd1;
                drain_left[i] = 32'd0;
            end
            for (int i = 0; i < NUM_CNT; i++)
                counts[i] = 32'd0;
            last_handle = 64'd0;
            last_mode = MODE_FREE;
            limit = LIMIT_RST;
            drain_time = DRAIN_RST;
            ready = 1'b0;
            fails = 0;
        endfunction

        function void apply_cfg(logic [1:0] idx, logic [31:0] data);
            if (idx == CFG_ACTIVE_LIMIT)
                limit = data[4:0];
            else if (idx == CFG_DRAIN_TIME)
                drain_time = data;
            else if (idx == CFG_READY)
                ready = data[0];
        endfunction

        function int pending();
            return awaited_rsp.size();
        endfunction

        function bit decode(logic [63:0] h, output int idx);
            idx = 0;
            if (h[31:0] == 32'd0 || h[31:0] > SLOTS)
                return 1'b0;
            idx = int'(h[31:0]) - 1;
            return h[63:32] != 32'd0 && slot_gen[idx] == h[63:32] && slot_mode[idx] != MODE_FREE;
        endfunction

        function void bump_gen(int i);
            slot_gen[i] = slot_gen[i] + 32'd1;
            if (slot_gen[i] == 32'd0)
                slot_gen[i] = 32'd1;
        endfunction

        function void begin_drain(int i, logic [63:0] h);
            slot_mode[i] = MODE_DRAIN;
            drain_left[i] = (drain_time < MIN_DRAIN) ? MIN_DRAIN : drain_time;
            counts[CNT_STOP]++;
            counts[CNT_DRAIN]++;
            last_handle = h;
            last_mode = MODE_DRAIN;
        endfunction

        function rsp_t compute_response(req_t r);
            rsp_t        o;
            int          idx;
            int          found;
            int          lim;
            logic [15:0] dt;
            logic [63:0] rh;
            o = '0;
            o.status = ST_INVALID;
            if (r.func == FUNC_START)
            begin
                if (r.handle != 64'd0 && decode(r.handle, idx))
                begin
                    counts[CNT_DUPSTART]++;
                    o.status = ST_DUP;
                    if (slot_mode[idx] == MODE_ACTIVE)
                    begin
                        o.handle_out = r.handle;
                        o.ok = 1'b1;
                    end
                end
                else if (!ready || !r.transform_ok)
                    counts[CNT_BADXF]++;
                else
                begin
                    lim = int'(limit);
                    if (lim < 1)
                        lim = 1;
                    if (lim > SLOTS)
                        lim = SLOTS;
                    found = -1;
                    for (int i = 0; i < lim; i++)
                        if (found < 0 && slot_mode[i] == MODE_FREE)
                            found = i;
                    if (found < 0)
                    begin
                        counts[CNT_SHORT]++;
                        o.status = ST_NOSLOT;
                    end
                    else
                    begin
                        slot_mode[found] = MODE_ACTIVE;
                        drain_left[found] = 32'd0;
                        o.handle_out = {slot_gen[found], 32'(found + 1)};
                        last_handle = o.handle_out;
                        last_mode = MODE_ACTIVE;
                        counts[CNT_ACQUIRE]++;
                        o.ok = 1'b1;
                        o.status = ST_OK;
                    end
                end
            end
            else if (r.func == FUNC_UPDATE)
            begin
                if (!decode(r.handle, idx) || slot_mode[idx] != MODE_ACTIVE)
                    o.status = ST_UNKNOWN;
                else if (!r.transform_ok)
                begin
                    counts[CNT_BADXF]++;
                    begin_drain(idx, r.handle);
                end
                else
                begin
                    last_handle = r.handle;
                    last_mode = MODE_ACTIVE;
                    o.ok = 1'b1;
                    o.status = ST_OK;
                end
            end
            else if (r.func == FUNC_STOP)
            begin
                if (!decode(r.handle, idx) || slot_mode[idx] != MODE_ACTIVE)
                begin
                    if (r.handle != 64'd0)
                        counts[CNT_DUPSTOP]++;
                    o.status = ST_BADSTOP;
                end
                else
                begin
                    begin_drain(idx, r.handle);
                    o.ok = 1'b1;
                    o.status = ST_OK;
                end
            end
            else if (r.func == FUNC_TICK)
            begin
                if (ready)
                begin
                    dt = (r.delta_time > MAX_STEP) ? MAX_STEP : r.delta_time;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (slot_mode[i] == MODE_DRAIN)
                        begin
                            drain_left[i] = (drain_left[i] > dt) ? drain_left[i] - dt : 32'd0;
                            if (drain_left[i] == 32'd0)
                            begin
                                rh = {slot_gen[i], 32'(i + 1)};
                                slot_mode[i] = MODE_FREE;
                                bump_gen(i);
                                counts[CNT_RELEASE]++;
                                o.released = o.released + 5'd1;
                                if (last_handle == rh)
                                    last_mode = MODE_FREE;
                            end
                        end
                    end
                    o.ok = 1'b1;
                    o.status = ST_OK;
                end
            end
            else if (r.func == FUNC_RESET)
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    slot_mode[i] = MODE_FREE;
                    drain_left[i] = 32'd0;
                    bump_gen(i);
                end
                last_handle = 64'd0;
                last_mode = MODE_FREE;
                if (r.clear_stats)
                    for (int i = 0; i < NUM_CNT; i++)
                        counts[i] = 32'd0;
                o.ok = 1'b1;
                o.status = ST_OK;
            end
            o.last_state = last_mode;
            o.stat_value = counts[r.stat_select];
            return o;
        endfunction

        function void note_request(req_t r);
            awaited_rsp = {awaited_rsp, compute_response(r)};
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                fails++;
            end
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (awaited_rsp.size() == 0)
            begin
                $error("response with no request outstanding");
                fails++;
                return;
            end
            want = awaited_rsp.pop_front();
            compare_field("ok", want.ok, got.ok);
            compare_field("handle_out", want.handle_out, got.handle_out);
            compare_field("status", want.status, got.status);
            compare_field("last_state", want.last_state, got.last_state);
            compare_field("released", want.released, got.released);
            compare_field("stat_value", want.stat_value, got.stat_value);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        req;
    logic        done;
    rsp_t        rsp;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_data;

    pool_scoreboard sb;
    bit             idle_on;
    int             cycle_count = 0;

    generational_slot_pool_with_drain #(.SLOTS(SLOTS)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    always @(posedge clk)
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_response(rsp);

    initial
    begin
        wait (cycle_count >= LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Hold start high until the request is taken; the caller sets start next.
    task automatic push_request(input req_t r);
        if (idle_on && $urandom_range(99) < 20)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic issue(input logic [2:0] func, input logic [63:0] h, input bit xf,
                         input logic [15:0] dt, input bit clr, input int sel);
        req_t r;
        r.func = func;
        r.handle = h;
        r.transform_ok = xf;
        r.delta_time = dt;
        r.clear_stats = clr;
        r.stat_select = 3'(sel);
        push_request(r);
    endtask

    // Drain the block before touching a register.
    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] data);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SLOTS + 4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.apply_cfg(idx, data);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [4:0] lim, input logic [31:0] drain, input bit rdy);
        write_cfg(CFG_ACTIVE_LIMIT, 32'(lim));
        write_cfg(CFG_DRAIN_TIME, drain);
        write_cfg(CFG_READY, 32'(rdy));
    endtask

    function automatic logic [63:0] slot_handle(int s);
        return {sb.slot_gen[s], 32'(s + 1)};
    endfunction

    function automatic logic [63:0] pick_handle();
        int s;
        int k;
        s = $urandom_range(SLOTS - 1);
        // favor slots in use so stops and updates mostly land
        for (k = 0; k < 4 && sb.slot_mode[s] == MODE_FREE; k++)
            s = $urandom_range(SLOTS - 1);
        case ($urandom_range(9))
            0: return 64'd0;
            1: return {sb.slot_gen[s] - 32'd1, 32'(s + 1)};
            2: return {sb.slot_gen[s],
                       $urandom_range(1) ? 32'd0 : 32'($urandom_range(32'hffff_ffff, SLOTS + 1))};
            3: return {$urandom, $urandom};
            default: return slot_handle(s);
        endcase
    endfunction

    function automatic req_t rand_request();
        req_t r;
        int   p;
        p = $urandom_range(99);
        r.handle = pick_handle();
        if (p < 30)
        begin
            r.func = FUNC_START;
            if ($urandom_range(9) < 7)
                r.handle = 64'd0;
        end
        else if (p < 45)
            r.func = FUNC_UPDATE;
        else if (p < 63)
            r.func = FUNC_STOP;
        else if (p < 93)
            r.func = FUNC_TICK;
        else if (p < 97)
            r.func = FUNC_RESET;
        else
            r.func = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
        r.transform_ok = ($urandom_range(99) < 85);
        p = $urandom_range(99);
        if (p < 40)
            r.delta_time = 16'($urandom_range(700));
        else if (p < 65)
            r.delta_time = 16'($urandom_range(MAX_STEP));
        else if (p < 85)
            r.delta_time = 16'($urandom);
        else
            case ($urandom_range(3))
                0: r.delta_time = 16'd0;
                1: r.delta_time = MAX_STEP;
                2: r.delta_time = MAX_STEP + 16'd1;
                default: r.delta_time = 16'hffff;
            endcase
        r.clear_stats = 1'($urandom_range(1));
        r.stat_select = 3'($urandom_range(7));
        return r;
    endfunction

    task automatic run_phase(input int n, input logic [4:0] lim, input logic [31:0] drain,
                             input bit rdy, input bit quiet);
        set_config(lim, drain, rdy);
        idle_on = !quiet;
        repeat (n) push_request(rand_request());
    endtask

    initial
    begin
        sb = new();
        idle_on = 1'b1;
        rst_n <= 1'b0;
        start <= 1'b0;
        req <= '0;
        cfg_we <= 1'b0;
        cfg_idx <= '0;
        cfg_data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pool not yet ready
        issue(FUNC_START, 64'd0, 1, 16'd0, 0, CNT_BADXF);
        issue(FUNC_TICK, 64'd0, 1, 16'hffff, 0, CNT_RELEASE);
        set_config(5'd2, 32'd700, 1'b1);
        issue(FUNC_START, 64'd0, 0, 16'd0, 0, CNT_BADXF);
        issue(FUNC_START, 64'd0, 1, 16'd0, 0, CNT_ACQUIRE);
        issue(FUNC_START, 64'd0, 1, 16'd0, 0, CNT_ACQUIRE);
        issue(FUNC_START, 64'd0, 1, 16'd0, 0, CNT_SHORT);
        issue(FUNC_START, slot_handle(0), 1, 16'd0, 0, CNT_DUPSTART);
        issue(FUNC_UPDATE, slot_handle(0), 1, 16'd0, 0, CNT_ACQUIRE);
        issue(FUNC_UPDATE, 64'd0, 1, 16'd0, 0, CNT_BADXF);
        // bad transform on update stops the slot
        issue(FUNC_UPDATE, slot_handle(1), 0, 16'd0, 0, CNT_BADXF);
        issue(FUNC_START, slot_handle(1), 1, 16'd0, 0, CNT_DUPSTART);
        issue(FUNC_STOP, slot_handle(1), 1, 16'd0, 0, CNT_DUPSTOP);
        issue(FUNC_STOP, 64'd0, 1, 16'd0, 0, CNT_DUPSTOP);
        issue(FUNC_STOP, slot_handle(0), 1, 16'd0, 0, CNT_STOP);
        issue(FUNC_TICK, 64'd0, 1, 16'd0, 0, CNT_RELEASE);
        issue(FUNC_TICK, 64'd0, 1, 16'hffff, 0, CNT_RELEASE);
        issue(FUNC_STOP, {sb.slot_gen[0] - 32'd1, 32'd1}, 1, 16'd0, 0, CNT_DUPSTOP);
        issue(FUNC_UPDATE, {32'd0, 32'd1}, 1, 16'd0, 0, CNT_DRAIN);
        issue(FUNC_UPDATE, {32'd1, 32'(SLOTS + 1)}, 1, 16'd0, 0, CNT_DUPSTART);
        issue(FUNC_STOP, 64'hffff_ffff_ffff_ffff, 1, 16'd0, 0, CNT_DUPSTOP);
        issue(FUNC_UNUSED_LO, 64'd0, 1, 16'd0, 0, CNT_ACQUIRE);
        issue(FUNC_UNUSED_HI, 64'd0, 1, 16'd0, 0, CNT_SHORT);
        issue(FUNC_RESET, 64'd0, 1, 16'd0, 0, CNT_RELEASE);
        issue(FUNC_RESET, 64'd0, 1, 16'd0, 1, CNT_STOP);

        run_phase(300, 5'd16, MIN_DRAIN, 1'b1, 1'b0);
        run_phase(250, 5'd1, 32'hffff_ffff, 1'b1, 1'b0);
        run_phase(300, 5'd4, 32'd300, 1'b1, 1'b1);
        run_phase(250, 5'd31, 32'd20000, 1'b1, 1'b0);
        run_phase(150, 5'd8, DRAIN_RST, 1'b0, 1'b0);
        run_phase(150, 5'd0, 32'd2000, 1'b1, 1'b0);
        write_cfg(CFG_SPARE, 32'hffff_ffff);
        run_phase(250, 5'd16, 32'd1500, 1'b1, 1'b0);

        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SLOTS + 24) @(posedge clk);
        if (sb.fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ generational_slot_pool_with_drain.f @@
rtl/gsp_pkg.sv
rtl/gsp_front.sv
rtl/gsp_queue.sv
rtl/gsp_back.sv
rtl/generational_slot_pool_with_drain.sv
rtl/gsp_checker.sv
verif/testbench.sv
